// File: rtl/core/vrt_pkg.sv
`timescale 1ns / 1ps

package vrt_pkg;

  // default fixed-point layout
  localparam int FRAC_BITS_DEF = 16;
  localparam int CELL_BITS_DEF = 16;

  localparam int OUTC_W = 3;
  localparam logic [OUTC_W-1:0] OUTC_PROBE  = 3'd0;
  localparam logic [OUTC_W-1:0] OUTC_HIT    = 3'd1;
  localparam logic [OUTC_W-1:0] OUTC_MISS   = 3'd2;
  localparam logic [OUTC_W-1:0] OUTC_REJECT = 3'd3;
  localparam logic [OUTC_W-1:0] OUTC_IDLE   = 3'd4;

  localparam logic [31:0] DIST_INF = 32'hFFFF_FFFF;
  localparam int ROOT_STEPS = 32;

  // datapath commands
  localparam int CMD_W = 4;
  localparam logic [CMD_W-1:0] CMD_NONE      = 4'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD      = 4'd1;
  localparam logic [CMD_W-1:0] CMD_PROBE     = 4'd2;
  localparam logic [CMD_W-1:0] CMD_SQ        = 4'd3;
  localparam logic [CMD_W-1:0] CMD_REJECT    = 4'd4;
  localparam logic [CMD_W-1:0] CMD_ROOT_INIT = 4'd5;
  localparam logic [CMD_W-1:0] CMD_ROOT_STEP = 4'd6;
  localparam logic [CMD_W-1:0] CMD_AXIS_INIT = 4'd7;
  localparam logic [CMD_W-1:0] CMD_DIV_STEP  = 4'd8;
  localparam logic [CMD_W-1:0] CMD_MUL       = 4'd9;
  localparam logic [CMD_W-1:0] CMD_STORE     = 4'd10;
  localparam logic [CMD_W-1:0] CMD_FINISH    = 4'd11;

  typedef struct packed {
    logic [CMD_W-1:0] op;
    logic [1:0]       axis;
  } vrt_cmd_t;

  typedef struct packed {
    logic sum_zero;   // squared length is zero
    logic dir_zero;   // direction of commanded axis is zero
    logic out_free;   // result register can take a word this cycle
  } vrt_stat_t;

endpackage

// File: rtl/core/vrt_ctrl.sv
`timescale 1ns / 1ps

module vrt_ctrl #(
  parameter int FRAC_BITS = vrt_pkg::FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_req_type,
  output logic              in_ready,
  input  vrt_pkg::vrt_stat_t stat,
  output vrt_pkg::vrt_cmd_t  cmd
);
  import vrt_pkg::*;

  localparam int DIV_STEPS = 32 + FRAC_BITS;
  localparam int CNT_W = $clog2(DIV_STEPS + 1);
  localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(DIV_STEPS - 1);
  localparam logic [CNT_W-1:0] ROOT_LAST = CNT_W'(ROOT_STEPS - 1);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SQ     = 4'd1;
  localparam logic [3:0] S_CHECK  = 4'd2;
  localparam logic [3:0] S_ROOT   = 4'd3;
  localparam logic [3:0] S_AINIT  = 4'd4;
  localparam logic [3:0] S_DIV    = 4'd5;
  localparam logic [3:0] S_MUL    = 4'd6;
  localparam logic [3:0] S_STORE  = 4'd7;
  localparam logic [3:0] S_FINISH = 4'd8;

  logic [3:0]       state_r, state_nxt;
  logic [1:0]       axis_r, axis_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign in_ready = (state_r == S_IDLE) && stat.out_free;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    axis_nxt  = axis_r;
    cnt_nxt   = cnt_r;
    cmd.op    = CMD_NONE;
    cmd.axis  = axis_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          if (in_req_type) begin
            cmd.op = CMD_PROBE;
          end else begin
            cmd.op    = CMD_LOAD;
            axis_nxt  = 2'd0;
            state_nxt = S_SQ;
          end
        end
      end
      S_SQ: begin
        cmd.op = CMD_SQ;
        if (axis_r == 2'd2) begin
          axis_nxt  = 2'd0;
          state_nxt = S_CHECK;
        end else begin
          axis_nxt = axis_r + 2'd1;
        end
      end
      S_CHECK: begin
        if (stat.sum_zero) begin
          cmd.op    = CMD_REJECT;
          state_nxt = S_IDLE;
        end else begin
          cmd.op    = CMD_ROOT_INIT;
          cnt_nxt   = '0;
          state_nxt = S_ROOT;
        end
      end
      S_ROOT: begin
        cmd.op  = CMD_ROOT_STEP;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == ROOT_LAST) begin
          axis_nxt  = 2'd0;
          state_nxt = S_AINIT;
        end
      end
      S_AINIT: begin
        cmd.op    = CMD_AXIS_INIT;
        cnt_nxt   = '0;
        state_nxt = stat.dir_zero ? S_STORE : S_DIV;
      end
      S_DIV: begin
        cmd.op  = CMD_DIV_STEP;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == DIV_LAST) state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.op    = CMD_MUL;
        state_nxt = S_STORE;
      end
      S_STORE: begin
        cmd.op = CMD_STORE;
        if (axis_r == 2'd2) begin
          state_nxt = S_FINISH;
        end else begin
          axis_nxt  = axis_r + 2'd1;
          state_nxt = S_AINIT;
        end
      end
      S_FINISH: begin
        cmd.op    = CMD_FINISH;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      axis_r  <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      axis_r  <= axis_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

// File: rtl/core/vrt_dp.sv
`timescale 1ns / 1ps

module vrt_dp #(
  parameter int FRAC_BITS = vrt_pkg::FRAC_BITS_DEF,
  parameter int CELL_BITS = vrt_pkg::CELL_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  vrt_pkg::vrt_cmd_t         cmd,
  output vrt_pkg::vrt_stat_t        stat,
  input  logic signed [31:0]        in_origin_x,
  input  logic signed [31:0]        in_origin_y,
  input  logic signed [31:0]        in_origin_z,
  input  logic signed [15:0]        in_dir_x,
  input  logic signed [15:0]        in_dir_y,
  input  logic signed [15:0]        in_dir_z,
  input  logic [31:0]               in_max_distance,
  input  logic                      in_solid,
  input  logic [15:0]               in_block_code,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [vrt_pkg::OUTC_W-1:0] out_outcome,
  output logic signed [15:0]        out_voxel_x,
  output logic signed [15:0]        out_voxel_y,
  output logic signed [15:0]        out_voxel_z,
  output logic signed [15:0]        out_prior_x,
  output logic signed [15:0]        out_prior_y,
  output logic signed [15:0]        out_prior_z,
  output logic [31:0]               out_travelled,
  output logic [15:0]               out_hit_block
);
  import vrt_pkg::*;

  localparam int NW = 32 + FRAC_BITS;         // dividend width
  localparam int PW = FRAC_BITS + 1 + 32;     // crossing product width
  localparam logic [CELL_BITS-1:0] CELL_ONE = CELL_BITS'(1);

  // start operands
  logic signed [31:0] org_r [3];
  logic signed [15:0] dir_r [3];
  logic [31:0]        limit_r;
  logic [31:0]        sum_r;

  // root and divide
  logic [63:0]   n_r, r_r, b_r;
  logic [NW-1:0] num_r;
  logic [31:0]   rem_r;
  logic [31:0]   den_r;
  logic          dz_r;
  logic [31:0]   delta_r;
  logic [PW-1:0] prod_r;

  // walk state
  logic [CELL_BITS-1:0] pos_r [3];
  logic [CELL_BITS-1:0] back_r [3];
  logic [5:0]           signs_r;
  logic [31:0]          cdelta_r [3];
  logic [31:0]          ncross_r [3];
  logic [31:0]          walked_r;
  logic                 live_r;

  // result word
  logic                  out_valid_r;
  logic [OUTC_W-1:0]     outc_r;
  logic [15:0]           vox_r [3];
  logic [15:0]           pri_r [3];
  logic [31:0]           trav_r;
  logic [15:0]           hblk_r;

  // axis-selected operands
  logic signed [15:0]  dsel;
  logic signed [31:0]  dwide;
  logic signed [31:0]  osel, osh;
  logic [15:0]         adsel;
  logic [31:0]         sq;
  logic [CELL_BITS-1:0] cell_sel;
  logic [FRAC_BITS:0]  k_sel;
  logic [31:0]         delta_sat, cross_sat;

  always_comb begin
    dsel  = dir_r[cmd.axis];
    osel  = org_r[cmd.axis];
    adsel = dsel[15] ? 16'(-dsel) : 16'(dsel);
    dwide = 32'(dsel);
    sq    = dwide * dwide;
    osh   = osel >>> FRAC_BITS;
    cell_sel = osh[CELL_BITS-1:0];
    k_sel = dsel[15] ? {1'b0, osel[FRAC_BITS-1:0]}
                     : ({1'b1, {FRAC_BITS{1'b0}}} - {1'b0, osel[FRAC_BITS-1:0]});
    delta_sat = (|num_r[NW-1:32]) ? DIST_INF : num_r[31:0];
    cross_sat = (dz_r || delta_r == DIST_INF || (|prod_r[PW-1:FRAC_BITS+32]))
              ? DIST_INF : prod_r[FRAC_BITS+31:FRAC_BITS];
  end

  // root and divide step logic
  logic [63:0] rt_sum;
  logic [32:0] rem_sh;
  logic        q_bit;
  always_comb begin
    rt_sum = r_r + b_r;
    rem_sh = {rem_r, num_r[NW-1]};
    q_bit  = (rem_sh >= {1'b0, den_r});
  end

  // probe step
  logic        sel0, sel1;
  logic [1:0]  pa;
  logic [31:0] step_dist, dstep, nc_new;
  logic [32:0] nc_sum;
  logic [1:0]  sg;
  logic [CELL_BITS-1:0] pos_new [3];
  logic        miss;
  always_comb begin
    sel0 = (ncross_r[0] <= ncross_r[1]) && (ncross_r[0] <= ncross_r[2]);
    sel1 = !sel0 && (ncross_r[1] <= ncross_r[2]);
    pa   = sel0 ? 2'd0 : (sel1 ? 2'd1 : 2'd2);
    step_dist = ncross_r[pa];
    dstep = cdelta_r[pa];
    nc_sum = {1'b0, step_dist} + {1'b0, dstep};
    nc_new = (step_dist == DIST_INF || dstep == DIST_INF || nc_sum[32])
           ? DIST_INF : nc_sum[31:0];
    sg = signs_r[2*pa +: 2];
    for (int i = 0; i < 3; i++) begin
      pos_new[i] = pos_r[i];
    end
    if (sg[0]) pos_new[pa] = sg[1] ? pos_r[pa] - CELL_ONE : pos_r[pa] + CELL_ONE;
    miss = (step_dist == DIST_INF) || (step_dist > limit_r);
  end

  function automatic logic [15:0] ext16(input logic [CELL_BITS-1:0] c);
    logic [31:0] w;
    w = {{(32-CELL_BITS){c[CELL_BITS-1]}}, c};
    return w[15:0];
  endfunction

  assign stat.sum_zero = (sum_r == '0);
  assign stat.dir_zero = (dsel == '0);
  assign stat.out_free = !out_valid_r || out_ready;

  // working registers
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      CMD_LOAD: begin
        org_r[0] <= in_origin_x; org_r[1] <= in_origin_y; org_r[2] <= in_origin_z;
        dir_r[0] <= in_dir_x;    dir_r[1] <= in_dir_y;    dir_r[2] <= in_dir_z;
        limit_r  <= in_max_distance;
        sum_r    <= '0;
      end
      CMD_SQ: sum_r <= sum_r + sq;
      CMD_ROOT_INIT: begin
        n_r <= {sum_r, 32'd0};
        r_r <= '0;
        b_r <= 64'd1 << 62;
      end
      CMD_ROOT_STEP: begin
        if (n_r >= rt_sum) begin
          n_r <= n_r - rt_sum;
          r_r <= (r_r >> 1) + b_r;
        end else begin
          r_r <= r_r >> 1;
        end
        b_r <= b_r >> 2;
      end
      CMD_AXIS_INIT: begin
        num_r <= NW'(r_r[31:0]) << FRAC_BITS;
        rem_r <= '0;
        den_r <= {adsel, 16'd0};
        dz_r  <= (dsel == '0);
      end
      CMD_DIV_STEP: begin
        rem_r <= q_bit ? 32'(rem_sh - {1'b0, den_r}) : rem_sh[31:0];
        num_r <= {num_r[NW-2:0], q_bit};
      end
      CMD_MUL: begin
        delta_r <= delta_sat;
        prod_r  <= PW'(k_sel) * PW'(delta_sat);
      end
      default: begin
      end
    endcase
  end

  // walk state and result word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        pos_r[i]    <= '0;
        back_r[i]   <= '0;
        cdelta_r[i] <= DIST_INF;
        ncross_r[i] <= DIST_INF;
      end
      signs_r     <= '0;
      walked_r    <= '0;
      live_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // result register: loaded by a result command, emptied when taken
      if (cmd.op == CMD_REJECT || cmd.op == CMD_FINISH || cmd.op == CMD_PROBE) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (cmd.op)
        CMD_LOAD: live_r <= 1'b0;
        CMD_REJECT: begin
          outc_r <= OUTC_REJECT;
          for (int i = 0; i < 3; i++) begin
            vox_r[i] <= '0;
            pri_r[i] <= '0;
          end
          trav_r <= '0;
          hblk_r <= '0;
        end
        CMD_STORE: begin
          pos_r[cmd.axis]    <= cell_sel;
          cdelta_r[cmd.axis] <= dz_r ? DIST_INF : delta_r;
          ncross_r[cmd.axis] <= cross_sat;
          signs_r[2*cmd.axis +: 2] <= dz_r ? 2'b00 : (dsel[15] ? 2'b11 : 2'b01);
        end
        CMD_FINISH: begin
          for (int i = 0; i < 3; i++) begin
            back_r[i] <= pos_r[i];
            vox_r[i]  <= ext16(pos_r[i]);
            pri_r[i]  <= '0;
          end
          walked_r    <= '0;
          live_r      <= 1'b1;
          outc_r      <= OUTC_PROBE;
          trav_r      <= '0;
          hblk_r      <= '0;
        end
        CMD_PROBE: begin
          trav_r <= '0;
          hblk_r <= '0;
          for (int i = 0; i < 3; i++) begin
            vox_r[i] <= '0;
            pri_r[i] <= '0;
          end
          priority if (!live_r) begin
            outc_r <= OUTC_IDLE;
          end else if (in_solid) begin
            outc_r <= OUTC_HIT;
            for (int i = 0; i < 3; i++) begin
              vox_r[i] <= ext16(pos_r[i]);
              pri_r[i] <= ext16(back_r[i]);
            end
            trav_r <= walked_r;
            hblk_r <= in_block_code;
            live_r <= 1'b0;
          end else begin
            for (int i = 0; i < 3; i++) begin
              back_r[i] <= pos_r[i];
              pos_r[i]  <= pos_new[i];
            end
            ncross_r[pa] <= nc_new;
            walked_r     <= step_dist;
            if (miss) begin
              outc_r <= OUTC_MISS;
              live_r <= 1'b0;
            end else begin
              outc_r <= OUTC_PROBE;
              for (int i = 0; i < 3; i++) begin
                vox_r[i] <= ext16(pos_new[i]);
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign out_valid     = out_valid_r;
  assign out_outcome   = outc_r;
  assign out_voxel_x   = vox_r[0];
  assign out_voxel_y   = vox_r[1];
  assign out_voxel_z   = vox_r[2];
  assign out_prior_x   = pri_r[0];
  assign out_prior_y   = pri_r[1];
  assign out_prior_z   = pri_r[2];
  assign out_travelled = trav_r;
  assign out_hit_block = hblk_r;

endmodule

// File: rtl/core/voxel_ray_traversal_stepper_top.sv
`timescale 1ns / 1ps

// Fixed-point 3D voxel walk (Amanatides-Woo stepping).
// Input channel (in_valid/in_ready): a start word (req_type 0) carries origin,
// direction and distance limit; an answer word (req_type 1) says whether the
// last probed voxel is solid and gives its block code.
// Result channel (out_valid/out_ready): one word per input word, held in an
// output register.
// Flow: an answer word's result is in the output register in the cycle after
// acceptance, and a new word is taken in the same cycle the previous result is
// taken, so probes run at one word per cycle while out_ready stays high. A start
// word runs a sum of squares over the three axes, a zero check, a 32-step square
// root, and per moving axis a setup step, a (32+FRAC_BITS)-step restoring divide,
// a multiply and a store; a fixed axis takes only the setup step and the store.
// A final step then loads the result word.
// A start word whose direction is all zero is rejected at the zero check.
// in_ready is low while a start is in progress and while the result register
// holds a word that is not taken this cycle; a stalled receiver simply holds
// off the next input word.
// Reset (synchronous, active low) drops any active ray and empties the output.
module voxel_ray_traversal_stepper_top #(
  parameter int FRAC_BITS = vrt_pkg::FRAC_BITS_DEF,
  parameter int CELL_BITS = vrt_pkg::CELL_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      in_req_type,
  input  logic signed [31:0]        in_origin_x,
  input  logic signed [31:0]        in_origin_y,
  input  logic signed [31:0]        in_origin_z,
  input  logic signed [15:0]        in_dir_x,
  input  logic signed [15:0]        in_dir_y,
  input  logic signed [15:0]        in_dir_z,
  input  logic [31:0]               in_max_distance,
  input  logic                      in_solid,
  input  logic [15:0]               in_block_code,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [vrt_pkg::OUTC_W-1:0] out_outcome,
  output logic signed [15:0]        out_voxel_x,
  output logic signed [15:0]        out_voxel_y,
  output logic signed [15:0]        out_voxel_z,
  output logic signed [15:0]        out_prior_x,
  output logic signed [15:0]        out_prior_y,
  output logic signed [15:0]        out_prior_z,
  output logic [31:0]               out_travelled,
  output logic [15:0]               out_hit_block
);
  import vrt_pkg::*;

  vrt_cmd_t  cmd;
  vrt_stat_t stat;

  vrt_ctrl #(.FRAC_BITS(FRAC_BITS)) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_req_type (in_req_type),
    .in_ready    (in_ready),
    .stat        (stat),
    .cmd         (cmd)
  );

  vrt_dp #(.FRAC_BITS(FRAC_BITS), .CELL_BITS(CELL_BITS)) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_origin_x     (in_origin_x),
    .in_origin_y     (in_origin_y),
    .in_origin_z     (in_origin_z),
    .in_dir_x        (in_dir_x),
    .in_dir_y        (in_dir_y),
    .in_dir_z        (in_dir_z),
    .in_max_distance (in_max_distance),
    .in_solid        (in_solid),
    .in_block_code   (in_block_code),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_outcome     (out_outcome),
    .out_voxel_x     (out_voxel_x),
    .out_voxel_y     (out_voxel_y),
    .out_voxel_z     (out_voxel_z),
    .out_prior_x     (out_prior_x),
    .out_prior_y     (out_prior_y),
    .out_prior_z     (out_prior_z),
    .out_travelled   (out_travelled),
    .out_hit_block   (out_hit_block)
  );

endmodule

// File: rtl/core/vrt_checker.sv
`timescale 1ns / 1ps

module vrt_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      in_req_type,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [vrt_pkg::OUTC_W-1:0] out_outcome,
  input logic signed [15:0]        out_prior_x,
  input logic signed [15:0]        out_prior_y,
  input logic signed [15:0]        out_prior_z,
  input logic [31:0]               out_travelled,
  input logic [15:0]               out_hit_block
);
  import vrt_pkg::*;

  // reset empties the result register
  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result word present after reset");

  // a held result word stays valid and its outcome does not change
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_outcome))
    else $error("result word dropped or changed while stalled");

  // an answer word's result is valid in the cycle after acceptance
  a_answer_lat: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_req_type |=> out_valid)
    else $error("answer word not resolved next cycle");

  // hit-only fields stay zero for other outcomes
  a_hit_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_outcome != OUTC_HIT |->
      out_travelled == '0 && out_hit_block == '0 &&
      out_prior_x == '0 && out_prior_y == '0 && out_prior_z == '0)
    else $error("hit fields set on a non-hit word");

endmodule

bind voxel_ray_traversal_stepper_top vrt_checker u_vrt_checker (.*);
